@@ sv/ple_pkg.sv @@
`default_nettype none

package ple_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int POS_W    = 5;
  localparam int LEN_W    = 5;
  localparam int STATUS_W = 2;

  // Entry index and entry count widths follow from the capacity
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Common width for comparing a request position with the count
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [DATA_W-1:0] ERR_VALUE = {DATA_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // One access to the entry memory: one write and one registered read per cycle
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

endpackage

`default_nettype wire

@@ sv/ple_req_if.sv @@
`default_nettype none

interface ple_req_if import ple_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   req_type;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] new_value;

  modport source (output valid, req_type, position, new_value, input ready);
  modport sink   (input valid, req_type, position, new_value, output ready);

endinterface

`default_nettype wire

@@ sv/ple_rsp_if.sv @@
`default_nettype none

interface ple_rsp_if import ple_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   entry_value;
  logic [LEN_W-1:0]    list_length;

  modport source (output valid, status, entry_value, list_length, input ready);
  modport sink   (input valid, status, entry_value, list_length, output ready);

endinterface

`default_nettype wire

@@ sv/ple_store.sv @@
`default_nettype none

module ple_store import ple_pkg::*; (
  input  wire logic              clk_i,
  input  wire ram_req_t          ram_req_i,
  output logic [DATA_W-1:0]      rdata_o
);

  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ram_req_i.we) begin
      mem_q[ram_req_i.waddr] <= ram_req_i.wdata;
    end
    rdata_q <= mem_q[ram_req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/ple_ctrl.sv @@
`default_nettype none

module ple_ctrl import ple_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  ple_req_if.sink           req_i,
  ple_rsp_if.source         rsp_o,
  output ram_req_t          ram_req_o,
  input  wire logic [DATA_W-1:0] rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_TAIL,
    S_INS_WR,
    S_DEL_RD,
    S_DN,
    S_DN_TAIL,
    S_RD_WAIT,
    S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [IDX_W-1:0]  lim_q, lim_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic              mv_q, mv_d;
  logic [IDX_W-1:0]  mv_addr_q, mv_addr_d;
  status_e           res_status_q, res_status_d;
  logic [DATA_W-1:0] res_val_q, res_val_d;
  logic [CNT_W-1:0]  res_len_q, res_len_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [DATA_W-1:0] out_val_q, out_val_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;

  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  cnt_m1;

  assign pos_ext = CMP_W'(req_i.position);
  assign cnt_ext = CMP_W'(count_q);
  assign cnt_m1  = cnt_ext - CMP_W'(1);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    pos_d        = pos_q;
    lim_d        = lim_q;
    val_d        = val_q;
    mv_d         = 1'b0;
    mv_addr_d    = mv_addr_q;
    res_status_d = res_status_q;
    res_val_d    = res_val_q;
    res_len_d    = res_len_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_val_d    = out_val_q;
    out_len_d    = out_len_q;

    ram_req_o.raddr = ptr_q;
    ram_req_o.we    = mv_q;
    ram_req_o.waddr = mv_addr_q;
    ram_req_o.wdata = rdata_i;

    unique case (state_q)
      S_IDLE: begin
        // Read the addressed entry right away for delete and read
        ram_req_o.raddr = pos_ext[IDX_W-1:0];
        if (req_i.valid) begin
          pos_d        = pos_ext[IDX_W-1:0];
          val_d        = req_i.new_value;
          res_status_d = ST_RANGE;
          res_val_d    = ERR_VALUE;
          state_d      = S_FIN;
          priority if (req_i.req_type == OP_INSERT) begin
            priority if (pos_ext > cnt_ext) begin
              res_status_d = ST_RANGE;
            end else if (cnt_ext >= CMP_W'(CAPACITY)) begin
              res_status_d = ST_FULL;
            end else begin
              res_status_d = ST_OK;
              res_val_d    = '0;
              count_d      = CNT_W'(count_q + 1'b1);
              if (pos_ext == cnt_ext) begin
                state_d = S_INS_WR;
              end else begin
                ptr_d   = cnt_m1[IDX_W-1:0];
                state_d = S_UP;
              end
            end
          end else if (req_i.req_type == OP_DELETE || req_i.req_type == OP_READ) begin
            priority if (count_q == '0) begin
              res_status_d = ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
              res_status_d = ST_RANGE;
            end else begin
              res_status_d = ST_OK;
              if (req_i.req_type == OP_READ) begin
                state_d = S_RD_WAIT;
              end else begin
                count_d = CNT_W'(count_q - 1'b1);
                lim_d   = cnt_m1[IDX_W-1:0];
                state_d = S_DEL_RD;
              end
            end
          end else begin
            res_status_d = ST_RANGE;
          end
          res_len_d = count_d;
        end
      end
      S_UP: begin
        // Move entries up by one, from the top down to the insert point
        ram_req_o.raddr = ptr_q;
        mv_d            = 1'b1;
        mv_addr_d       = IDX_W'(ptr_q + 1'b1);
        if (ptr_q == pos_q) begin
          state_d = S_UP_TAIL;
        end else begin
          ptr_d = IDX_W'(ptr_q - 1'b1);
        end
      end
      S_UP_TAIL: begin
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = pos_q;
        ram_req_o.wdata = val_q;
        state_d         = S_FIN;
      end
      S_DEL_RD: begin
        res_val_d = rdata_i;
        if (pos_q == lim_q) begin
          state_d = S_FIN;
        end else begin
          ptr_d   = IDX_W'(pos_q + 1'b1);
          state_d = S_DN;
        end
      end
      S_DN: begin
        // Move entries above the deleted one down by one
        ram_req_o.raddr = ptr_q;
        mv_d            = 1'b1;
        mv_addr_d       = IDX_W'(ptr_q - 1'b1);
        if (ptr_q == lim_q) begin
          state_d = S_DN_TAIL;
        end else begin
          ptr_d = IDX_W'(ptr_q + 1'b1);
        end
      end
      S_DN_TAIL: begin
        state_d = S_FIN;
      end
      S_RD_WAIT: begin
        res_val_d = rdata_i;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_val_d    = res_val_q;
          out_len_d    = LEN_W'(res_len_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      ptr_q        <= '0;
      pos_q        <= '0;
      lim_q        <= '0;
      val_q        <= '0;
      mv_q         <= 1'b0;
      mv_addr_q    <= '0;
      res_status_q <= ST_OK;
      res_val_q    <= '0;
      res_len_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_val_q    <= '0;
      out_len_q    <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      ptr_q        <= ptr_d;
      pos_q        <= pos_d;
      lim_q        <= lim_d;
      val_q        <= val_d;
      mv_q         <= mv_d;
      mv_addr_q    <= mv_addr_d;
      res_status_q <= res_status_d;
      res_val_q    <= res_val_d;
      res_len_q    <= res_len_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_val_q    <= out_val_d;
      out_len_q    <= out_len_d;
    end
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_value = out_val_q;
  assign rsp_o.list_length = out_len_q;

endmodule

`default_nettype wire

@@ sv/positional_list_engine.sv @@
`default_nettype none

// Channel  Dir  Fields                                   Transfer
// req_i    in   req_type[1:0] position[4:0] new_value    valid && ready
// rsp_o    out  status[1:0] entry_value list_length[4:0] valid && ready
//
// Insert and delete move the entries between the position and the end
// of the list; read, any error, insert at the end and delete of the last
// entry need no moves.
// The moves go one entry a cycle through the single write port of the
// entry memory; ready is high only while no request is in progress.
// Reset clears the entry count and the control state; entry memory
// contents are not cleared, since no read reaches an unwritten entry.
// A stalled response holds in the output register; the next request is
// taken meanwhile and waits at its end for the register to free up.
module positional_list_engine import ple_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ple_req_if.sink   req_i,
  ple_rsp_if.source rsp_o
);

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  // Sequencer: decode, move entries, format the response
  ple_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .ram_req_o (ram_req),
    .rdata_i   (ram_rdata)
  );

  // Entry memory: one write, one registered read per cycle
  ple_store u_store (
    .clk_i     (clk_i),
    .ram_req_i (ram_req),
    .rdata_o   (ram_rdata)
  );

`ifndef SYNTHESIS
  // One request at a time: a transfer drops ready in the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while another is in progress");

  // Any error returns the error value
  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_OK) |-> rsp_o.entry_value == ERR_VALUE)
    else $error("error response without error value");

  // Reported length never exceeds capacity
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.list_length <= LEN_W'(CAPACITY)))
    else $error("list length above capacity");
`endif

endmodule

`default_nettype wire
